FILE: rtl/tkpf_pkg.sv
// ----------------------------------------------------------------------------
// tkpf_pkg
// Shared types and constants for the top-k pulse peak finder.
// ----------------------------------------------------------------------------
package tkpf_pkg;
  localparam int unsigned ChargeW = 18;
  localparam int unsigned SlotW   = 21;
  localparam int unsigned TotalW  = 24;
  localparam int unsigned CountW  = 4;

  typedef logic [ChargeW-1:0] charge_t;
  typedef logic [SlotW-1:0]   slot_t;
  typedef logic [TotalW-1:0]  total_t;

  // Commands given to every cell of the kept-pulse cell row.
  typedef struct packed {
    logic insert;
    logic clear;
  } cell_cmd_t;
endpackage

FILE: rtl/tkpf_cell.sv
// ----------------------------------------------------------------------------
// tkpf_cell
// One kept-pulse slot: total and samples, part of an ascending sorted row.
// ----------------------------------------------------------------------------
module tkpf_cell #(
  parameter int unsigned MaxSamples = 10,
  parameter int unsigned SumW       = 22
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  tkpf_pkg::cell_cmd_t         cmd_i,
  input  logic [SumW-1:0]             new_total_i,
  input  tkpf_pkg::charge_t [MaxSamples-1:0] new_samples_i,
  input  logic                        last_i,
  input  logic [SumW-1:0]             up_total_i,
  input  tkpf_pkg::charge_t [MaxSamples-1:0] up_samples_i,
  input  logic                        up_less_i,
  input  logic                        down_take_i,
  output logic                        less_o,
  output logic [SumW-1:0]             total_o,
  output tkpf_pkg::charge_t [MaxSamples-1:0] samples_o
);
  import tkpf_pkg::*;

  logic [SumW-1:0] total_q, total_d;
  charge_t [MaxSamples-1:0] samples_q, samples_d;
  logic take;

  // less_o: this slot's total is strictly below the newcomer
  assign less_o = total_q < new_total_i;
  // slot position shifts down when the upper neighbor is also below
  assign take   = less_o;

  always_comb begin
    total_d   = total_q;
    samples_d = samples_q;
    if (cmd_i.clear) begin
      total_d   = '0;
      samples_d = '0;
    end else if (cmd_i.insert && take && down_take_i) begin
      if (!last_i && up_less_i) begin
        total_d   = up_total_i;
        samples_d = up_samples_i;
      end else begin
        total_d   = new_total_i;
        samples_d = new_samples_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q   <= '0;
      samples_q <= '0;
    end else begin
      total_q   <= total_d;
      samples_q <= samples_d;
    end
  end

  assign total_o   = total_q;
  assign samples_o = samples_q;
endmodule

FILE: rtl/top_k_pulse_peak_finder_unit.sv
// ----------------------------------------------------------------------------
// top_k_pulse_peak_finder_unit
// Keeps the largest pulses of an event and reports the summed peak.
// ----------------------------------------------------------------------------
// A sample is taken while busy is low. A pulse end adds a sorted insertion
// into the cell row (StIns). An event end then adds two passes over the
// slots, one slot per cycle in each pass (StSum, StOut), and a result state
// (StFin), in which result_valid_o is high for a single cycle. Busy stays
// high from the last sample of an event until StFin ends. The receiver cannot
// stall. Configuration is taken only while busy is low.
module top_k_pulse_peak_finder_unit #(
  parameter int unsigned TOP_COUNT   = 5,
  parameter int unsigned MAX_SAMPLES = 10
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tkpf_pkg::charge_t          charge_i,
  input  logic                       end_of_pulse_i,
  input  logic                       end_of_event_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [3:0]                 cfg_data_i,
  output logic                       result_valid_o,
  output logic [3:0]                 peak_index_o,
  output tkpf_pkg::slot_t            peak_charge_o,
  output tkpf_pkg::slot_t            next_charge_o,
  output logic                       next_valid_o,
  output tkpf_pkg::slot_t            second_charge_o,
  output logic                       second_valid_o,
  output tkpf_pkg::total_t           grand_total_o,
  output tkpf_pkg::total_t           off_peak_total_o
);
  import tkpf_pkg::*;

  localparam int unsigned SumW  = ChargeW + $clog2(MAX_SAMPLES + 1);
  localparam int unsigned IdxW  = $clog2(MAX_SAMPLES);
  localparam int unsigned PosW  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AccW  = ChargeW + $clog2(TOP_COUNT * MAX_SAMPLES + 1);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StIns  = 3'd1;
  localparam logic [2:0] StSum  = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;

  logic [2:0] st_q, st_d;
  logic [CountW-1:0] cfg_q;
  logic [PosW-1:0] n_eff;
  logic [PosW-1:0] pos_q;
  logic [SumW-1:0] psum_q;
  charge_t [MAX_SAMPLES-1:0] pbuf_q;
  logic eoe_q;
  logic accept;

  assign accept      = start && !busy;
  assign busy        = st_q != StIdle;
  assign cfg_ready_o = !busy;

  always_comb begin
    if (cfg_q == 4'd0) n_eff = PosW'(1);
    else if (32'(cfg_q) > MAX_SAMPLES) n_eff = PosW'(MAX_SAMPLES);
    else n_eff = PosW'(cfg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cfg_q <= 4'd10;
    else if (cfg_valid_i && cfg_ready_o) cfg_q <= cfg_data_i;
  end

  // cell row
  cell_cmd_t cmd;
  logic [TOP_COUNT-1:0] less;
  logic [TOP_COUNT-1:0][SumW-1:0] tot;
  charge_t [TOP_COUNT-1:0][MAX_SAMPLES-1:0] smp;
  logic [TOP_COUNT-1:0] take_chain;

  assign cmd.insert = st_q == StIns;
  assign cmd.clear  = st_q == StFin;
  // a cell takes part when all cells below it (smaller) are below the newcomer
  assign take_chain[0] = 1'b1;

  for (genvar g = 0; g < TOP_COUNT; g++) begin : g_cell
    logic up_less;
    logic [SumW-1:0] up_tot;
    charge_t [MAX_SAMPLES-1:0] up_smp;
    if (g == TOP_COUNT - 1) begin : g_top
      assign up_less = 1'b0;
      assign up_tot  = '0;
      assign up_smp  = '0;
    end else begin : g_mid
      assign up_less = less[g+1];
      assign up_tot  = tot[g+1];
      assign up_smp  = smp[g+1];
      assign take_chain[g+1] = take_chain[g] && less[g];
    end
    tkpf_cell #(.MaxSamples(MAX_SAMPLES), .SumW(SumW)) u_cell (
      .clk_i, .rst_ni,
      .cmd_i        (cmd),
      .new_total_i  (psum_q),
      .new_samples_i(pbuf_q),
      .last_i       (g == TOP_COUNT - 1),
      .up_total_i   (up_tot),
      .up_samples_i (up_smp),
      .up_less_i    (up_less),
      .down_take_i  (take_chain[g]),
      .less_o       (less[g]),
      .total_o      (tot[g]),
      .samples_o    (smp[g])
    );
  end

  // pulse capture
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      psum_q <= '0;
      pbuf_q <= '0;
      eoe_q  <= 1'b0;
    end else if (accept) begin
      if (pos_q < n_eff) begin
        pbuf_q[pos_q[IdxW-1:0]] <= charge_i;
        psum_q <= psum_q + SumW'(charge_i);
        pos_q  <= pos_q + 1'b1;
      end
      eoe_q <= end_of_event_i;
    end else if (st_q == StIns) begin
      pos_q  <= '0;
      psum_q <= '0;
      pbuf_q <= '0;
    end
  end

  // slot summing walk
  logic [PosW-1:0] idx_q;
  logic [AccW-1:0] slot_sum;
  logic [AccW-1:0] tot_q, pk_q;
  logic [IdxW-1:0] pki_q;
  logic [AccW-1:0] p1_q, p2_q, win_q;
  logic [PosW:0]   pk_ext;

  always_comb begin
    slot_sum = '0;
    for (int k = 0; k < TOP_COUNT; k++)
      slot_sum = slot_sum + AccW'(smp[k][idx_q[IdxW-1:0]]);
  end

  // window accumulation pass needs a second walk; keep slot sums in a row
  logic [MAX_SAMPLES-1:0][AccW-1:0] sl_q;
  logic [PosW-1:0] oidx_q;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (accept && (end_of_pulse_i || end_of_event_i)) st_d = StIns;
      StIns:  st_d = eoe_q ? StSum : StIdle;
      StSum:  if (idx_q + 1'b1 >= n_eff) st_d = StOut;
      StOut:  if (oidx_q + 1'b1 >= n_eff) st_d = StFin;
      StFin:  st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign pk_ext = {1'b0, PosW'(pki_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= StIdle;
      idx_q  <= '0;
      oidx_q <= '0;
      tot_q  <= '0;
      pk_q   <= '0;
      pki_q  <= '0;
      p1_q   <= '0;
      p2_q   <= '0;
      win_q  <= '0;
      sl_q   <= '0;
    end else begin
      st_q <= st_d;
      unique case (st_q)
        StSum: begin
          sl_q[idx_q[IdxW-1:0]] <= slot_sum;
          tot_q <= tot_q + slot_sum;
          if (slot_sum > pk_q) begin
            pk_q  <= slot_sum;
            pki_q <= idx_q[IdxW-1:0];
          end
          idx_q <= idx_q + 1'b1;
        end
        StOut: begin
          if ({1'b0, oidx_q} + 1'b1 >= pk_ext && {1'b0, oidx_q} <= pk_ext + 2'd2)
            win_q <= win_q + sl_q[oidx_q[IdxW-1:0]];
          if ({1'b0, oidx_q} == pk_ext + 1'b1) p1_q <= sl_q[oidx_q[IdxW-1:0]];
          if ({1'b0, oidx_q} == pk_ext + 2'd2) p2_q <= sl_q[oidx_q[IdxW-1:0]];
          oidx_q <= oidx_q + 1'b1;
        end
        StFin: begin
          idx_q  <= '0;
          oidx_q <= '0;
          tot_q  <= '0;
          pk_q   <= '0;
          pki_q  <= '0;
          p1_q   <= '0;
          p2_q   <= '0;
          win_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  logic [AccW-1:0] outer;
  assign outer = tot_q - win_q;

  assign result_valid_o   = st_q == StFin;
  assign peak_index_o     = 4'(pki_q);
  assign peak_charge_o    = SlotW'(pk_q);
  assign next_valid_o     = {1'b0, pk_ext} + 1'b1 < {2'b0, n_eff};
  assign second_valid_o   = {1'b0, pk_ext} + 2'd2 < {2'b0, n_eff};
  assign next_charge_o    = SlotW'(p1_q);
  assign second_charge_o  = SlotW'(p2_q);
  assign grand_total_o    = TotalW'(tot_q);
  assign off_peak_total_o = TotalW'(outer);

  a_busy_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy) else $error("result outside burst");
  a_ins_eoe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StIns && eoe_q) |=> st_q == StSum) else $error("missed sum");
  a_win: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> win_q <= tot_q) else $error("window exceeds total");
endmodule
